// ===== rtl/core/tlsr_pkg.sv =====
// Shared types, widths and codes for the thick line span rasterizer.
// No dependencies; every other file in rtl/core imports this package.
package tlsr_pkg;

    localparam int COORD_W       = 6;
    localparam int THICK_W       = 4;
    localparam int HALF_W        = 3;
    localparam int ERR_W         = 9;
    localparam int GRID_SIZE_DEF = 64;
    localparam int LIMIT_RESET   = 15;

    // Stream payload widths (tdata padded to whole bytes)
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_ADDR_W = 1;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROW_LIMIT = 1'b0,
        REG_COL_LIMIT = 1'b1
    } cfg_reg_t;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_WALK  = 3'b100
    } state_t;

    // Position and error of the line walk
    typedef struct packed {
        logic                     rows_major;
        logic                     major_dir;
        logic                     minor_dir;
        logic [COORD_W-1:0]       major_pos;
        logic [COORD_W-1:0]       minor_pos;
        logic [COORD_W-1:0]       major_end;
        logic signed [ERR_W-1:0]  err;
    } walk_state_t;

    // One clipped span
    typedef struct packed {
        logic [COORD_W-1:0] row_first;
        logic [COORD_W-1:0] row_last;
        logic [COORD_W-1:0] col_first;
        logic [COORD_W-1:0] col_last;
        logic               span_empty;
    } span_t;

endpackage

// ===== rtl/core/thick_line_span_rasterizer_core.sv =====
// Top level of the thick line span rasterizer: sequencer, output register, config.
// Depends on tlsr_pkg, tlsr_step and tlsr_span.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------------
//  s_*      | in  | s_tvalid / s_tready | line request: endpoints and thickness
//  m_*      | out | m_tvalid / m_tready | one span per major point, tlast on the last
//  cfg_*    | in  | cfg_we              | row_limit / col_limit writes
//
// A request yields N = |major delta| + 1 spans (1..GRID_SIZE): the request is latched,
// the walk is set up, then one span per cycle comes from the step unit while m_tready
// does not stall. s_tready is high only while the sequencer is idle.
// A stall on m_tready holds the walk in place. Reset clears control state and
// sets both limits to 15 (saturated to GRID_SIZE - 1).
module thick_line_span_rasterizer_core #(
    parameter int GRID_SIZE = tlsr_pkg::GRID_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_row[5:0], start_col[11:6], end_row[17:12], end_col[23:18],
    // thickness[27:24], zero pad[31:28]
    input  logic [tlsr_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // row_first[5:0], row_last[11:6], col_first[17:12], col_last[23:18]
    output logic [tlsr_pkg::M_TDATA_W-1:0]     m_tdata,
    // span_empty[0]
    output logic [tlsr_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [tlsr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tlsr_pkg::COORD_W-1:0]       cfg_wdata
);
    import tlsr_pkg::*;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);
    localparam logic [COORD_W-1:0] LIMIT_RST =
        (LIMIT_RESET > GRID_SIZE - 1) ? COORD_W'(GRID_SIZE - 1) : COORD_W'(LIMIT_RESET);

    function automatic logic [COORD_W-1:0] sat(input logic [COORD_W-1:0] v);
        sat = (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    state_t                  state_reg, state_next;
    logic [COORD_W-1:0]      row_limit_reg, col_limit_reg;
    logic [COORD_W-1:0]      r0_reg, c0_reg, r1_reg, c1_reg;
    logic [HALF_W-1:0]       half_reg;
    walk_state_t             walk_reg, walk_next, walk_step;
    logic signed [ERR_W-1:0] inc_straight_reg, inc_diag_reg;
    span_t                   span_cur, out_span_reg;
    logic                    out_valid_reg, out_last_reg;

    logic                    in_take;
    logic                    load;
    logic                    at_end;
    logic [COORD_W-1:0]      dr, dc, dmaj, dmin;
    logic                    setup_rows_major;
    logic signed [ERR_W-1:0] two_dmin, dmaj_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign at_end   = (walk_reg.major_pos == walk_reg.major_end);
    assign load     = (state_reg == ST_WALK) && (!out_valid_reg || m_tready);

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_limit_reg <= LIMIT_RST;
            col_limit_reg <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ROW_LIMIT: row_limit_reg <= sat(cfg_wdata);
                REG_COL_LIMIT: col_limit_reg <= sat(cfg_wdata);
                default: ;
            endcase
        end
    end

    // Latch the saturated request
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            r0_reg   <= sat(s_tdata[COORD_W-1:0]);
            c0_reg   <= sat(s_tdata[2*COORD_W-1:COORD_W]);
            r1_reg   <= sat(s_tdata[3*COORD_W-1:2*COORD_W]);
            c1_reg   <= sat(s_tdata[4*COORD_W-1:3*COORD_W]);
            half_reg <= s_tdata[4*COORD_W+THICK_W-1:4*COORD_W+1];
        end
    end

    // Walk setup: pick the major axis, directions and error increments
    assign dr = (r0_reg > r1_reg) ? r0_reg - r1_reg : r1_reg - r0_reg;
    assign dc = (c0_reg > c1_reg) ? c0_reg - c1_reg : c1_reg - c0_reg;
    assign setup_rows_major = (dc <= dr);
    assign dmaj = setup_rows_major ? dr : dc;
    assign dmin = setup_rows_major ? dc : dr;
    assign two_dmin = $signed({2'b00, dmin, 1'b0});
    assign dmaj_ext = $signed(ERR_W'(dmaj));

    always_comb
    begin
        walk_next = walk_reg;
        if (state_reg == ST_SETUP)
        begin
            walk_next.rows_major = setup_rows_major;
            if (setup_rows_major)
            begin
                walk_next.major_pos = r0_reg;
                walk_next.major_end = r1_reg;
                walk_next.minor_pos = c0_reg;
                walk_next.major_dir = (r1_reg < r0_reg);
                walk_next.minor_dir = (c1_reg < c0_reg);
            end
            else
            begin
                walk_next.major_pos = c0_reg;
                walk_next.major_end = c1_reg;
                walk_next.minor_pos = r0_reg;
                walk_next.major_dir = (c1_reg < c0_reg);
                walk_next.minor_dir = (r1_reg < r0_reg);
            end
            walk_next.err = two_dmin - dmaj_ext;
        end
        else if (load && !at_end)
        begin
            walk_next = walk_step;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;
        if (state_reg == ST_SETUP)
        begin
            inc_straight_reg <= two_dmin;
            inc_diag_reg     <= two_dmin - (dmaj_ext <<< 1);
        end
    end

    tlsr_step u_step (
        .cur          (walk_reg),
        .inc_straight (inc_straight_reg),
        .inc_diag     (inc_diag_reg),
        .nxt          (walk_step)
    );

    tlsr_span u_span (
        .cur        (walk_reg),
        .half_width (half_reg),
        .row_limit  (row_limit_reg),
        .col_limit  (col_limit_reg),
        .span       (span_cur)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_take) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_WALK;
            ST_WALK:  if (load && at_end) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register: hold the span until the sink takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_span_reg <= span_cur;
            out_last_reg <= at_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_span_reg.col_last, out_span_reg.col_first,
                       out_span_reg.row_last, out_span_reg.row_first};
    assign m_tuser  = out_span_reg.span_empty;
    assign m_tlast  = out_last_reg;

    // The final span sends the sequencer back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && at_end) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the final span");

    // The Bresenham error term stays within +/-126, twice the largest major delta
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |->
        (walk_reg.err >= -ERR_W'(126) && walk_reg.err <= ERR_W'(126)))
        else $error("error term out of range");

    // A non-empty span is ordered on both axes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_span_reg.span_empty) |->
        (out_span_reg.row_first <= out_span_reg.row_last &&
         out_span_reg.col_first <= out_span_reg.col_last))
        else $error("span bounds out of order");

endmodule

// ===== rtl/core/tlsr_step.sv =====
// Bresenham step unit: one error update, one major advance and a conditional minor advance per use.
// Depends on tlsr_pkg.
module tlsr_step (
    input  tlsr_pkg::walk_state_t                   cur,
    input  logic signed [tlsr_pkg::ERR_W-1:0]       inc_straight,
    input  logic signed [tlsr_pkg::ERR_W-1:0]       inc_diag,
    output tlsr_pkg::walk_state_t                   nxt
);
    import tlsr_pkg::*;

    logic                    err_le0;
    logic signed [ERR_W-1:0] inc_sel;

    // Pick the increment from the sign of the error term
    assign err_le0 = cur.err[ERR_W-1] || (cur.err == '0);
    assign inc_sel = err_le0 ? inc_straight : inc_diag;

    // Advance the walk by one major-axis point
    always_comb
    begin
        nxt           = cur;
        nxt.err       = cur.err + inc_sel;
        nxt.major_pos = cur.major_dir ? cur.major_pos - COORD_W'(1)
                                      : cur.major_pos + COORD_W'(1);
        if (!err_le0)
        begin
            nxt.minor_pos = cur.minor_dir ? cur.minor_pos - COORD_W'(1)
                                          : cur.minor_pos + COORD_W'(1);
        end
    end

endmodule

// ===== rtl/core/tlsr_span.sv =====
// Span builder: widens the current point by the half width and clips it.
// Depends on tlsr_pkg.
module tlsr_span (
    input  tlsr_pkg::walk_state_t               cur,
    input  logic [tlsr_pkg::HALF_W-1:0]         half_width,
    input  logic [tlsr_pkg::COORD_W-1:0]        row_limit,
    input  logic [tlsr_pkg::COORD_W-1:0]        col_limit,
    output tlsr_pkg::span_t                     span
);
    import tlsr_pkg::*;

    localparam int EXT_W = COORD_W + 2;

    logic [COORD_W-1:0]      maj_lim;
    logic [COORD_W-1:0]      min_lim;
    logic signed [EXT_W-1:0] lo;
    logic [EXT_W-1:0]        hi;
    logic                    empty;
    logic [COORD_W-1:0]      first;
    logic [COORD_W-1:0]      last;
    logic [COORD_W-1:0]      maj;

    assign maj_lim = cur.rows_major ? row_limit : col_limit;
    assign min_lim = cur.rows_major ? col_limit : row_limit;

    // Span ends around the minor center
    assign lo = $signed({2'b00, cur.minor_pos}) - $signed(EXT_W'(half_width));
    assign hi = {2'b00, cur.minor_pos} + EXT_W'(half_width);

    assign empty = (cur.major_pos > maj_lim) || (lo > $signed({2'b00, min_lim}));

    // Clip to the configured limits; an empty span reads as all zeros
    always_comb
    begin
        first = '0;
        last  = '0;
        maj   = '0;
        if (!empty)
        begin
            first = lo[EXT_W-1] ? '0 : lo[COORD_W-1:0];
            last  = (hi > {2'b00, min_lim}) ? min_lim : hi[COORD_W-1:0];
            maj   = cur.major_pos;
        end
    end

    always_comb
    begin
        span.span_empty = empty;
        if (cur.rows_major)
        begin
            span.row_first = maj;
            span.row_last  = maj;
            span.col_first = first;
            span.col_last  = last;
        end
        else
        begin
            span.row_first = first;
            span.row_last  = last;
            span.col_first = maj;
            span.col_last  = maj;
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for thick_line_span_rasterizer_core: random and directed line requests,
// spans predicted in-bench and checked in order. Depends on tlsr_pkg and the core RTL.
module testbench;

    import tlsr_pkg::*;

    // Flow-control profiles for source and sink
    typedef enum logic [1:0] {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL
    } pace_t;

    // One expected span with its end-of-line flag
    typedef struct {
        span_t span;
        logic  end_of_line;
    } span_due_t;

    localparam int GRID_MAX      = GRID_SIZE_DEF - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PRINT_CAP     = 50;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_ROW_LIMIT;
    logic [COORD_W-1:0]    cfg_wdata = '0;

    logic [S_TDATA_W-1:0] line_reqs_pending[$];
    span_due_t            spans_due[$];
    int                   row_lim = LIMIT_RESET;
    int                   col_lim = LIMIT_RESET;
    int                   mismatch_count = 0;
    int                   spans_checked = 0;
    logic                 req_accepted = 1'b0;
    pace_t                pace = PACE_SLOW_SINK;
    logic                 hold_go = 1'b0;
    logic                 hold_started = 1'b0;
    int                   hold_left = 0;

    thick_line_span_rasterizer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Build a line request word: fields from the lowest bit up, pad bits zero
    function automatic logic [S_TDATA_W-1:0] pack_req(int r0, int c0, int r1, int c1, int thick);
        logic [S_TDATA_W-1:0] w;
        w = '0;
        w[5:0]   = 6'(r0);
        w[11:6]  = 6'(c0);
        w[17:12] = 6'(r1);
        w[23:18] = 6'(c1);
        w[27:24] = 4'(thick);
        return w;
    endfunction

    // Clip one span against the configured limits and queue it
    function automatic void push_span(bit by_rows, int maj, int mnr, int half, bit last);
        span_due_t s;
        int        maj_lim;
        int        min_lim;
        int        lo;
        int        hi;
        bit        empty;
        maj_lim = by_rows ? row_lim : col_lim;
        min_lim = by_rows ? col_lim : row_lim;
        lo = mnr - half;
        hi = mnr + half;
        empty = (maj > maj_lim) || (lo > min_lim);
        if (empty)
        begin
            lo  = 0;
            hi  = 0;
            maj = 0;
        end
        else
        begin
            if (lo < 0)
                lo = 0;
            if (hi > min_lim)
                hi = min_lim;
        end
        if (by_rows)
        begin
            s.span.row_first = 6'(maj);
            s.span.row_last  = 6'(maj);
            s.span.col_first = 6'(lo);
            s.span.col_last  = 6'(hi);
        end
        else
        begin
            s.span.row_first = 6'(lo);
            s.span.row_last  = 6'(hi);
            s.span.col_first = 6'(maj);
            s.span.col_last  = 6'(maj);
        end
        s.span.span_empty = empty;
        s.end_of_line     = last;
        spans_due.push_back(s);
    endfunction

    // Walk the line with the midpoint error term and queue every span it yields
    function automatic void predict_line_spans(logic [S_TDATA_W-1:0] req);
        int r0, c0, r1, c1, dr, dc;
        int maj, mnr, maj_end, mnr_end, dmaj, dmin;
        int half, err, inc_straight, inc_diag, cnt;
        bit by_rows, maj_down, mnr_down;
        r0 = req[5:0];
        c0 = req[11:6];
        r1 = req[17:12];
        c1 = req[23:18];
        half = req[27:24] >> 1;
        dr = (r0 > r1) ? r0 - r1 : r1 - r0;
        dc = (c0 > c1) ? c0 - c1 : c1 - c0;
        by_rows = (dc <= dr);
        if (by_rows)
        begin
            maj = r0; maj_end = r1; mnr = c0; mnr_end = c1; dmaj = dr; dmin = dc;
        end
        else
        begin
            maj = c0; maj_end = c1; mnr = r0; mnr_end = r1; dmaj = dc; dmin = dr;
        end
        maj_down = (maj_end < maj);
        mnr_down = (mnr_end < mnr);
        err = 2 * dmin - dmaj;
        inc_straight = 2 * dmin;
        inc_diag = 2 * (dmin - dmaj);
        push_span(by_rows, maj, mnr, half, maj == maj_end);
        cnt = 1;
        while (maj != maj_end && cnt < GRID_SIZE_DEF)
        begin
            if (err <= 0)
                err += inc_straight;
            else
            begin
                err += inc_diag;
                mnr = mnr_down ? mnr - 1 : mnr + 1;
            end
            maj = maj_down ? maj - 1 : maj + 1;
            push_span(by_rows, maj, mnr, half, maj == maj_end);
            cnt++;
        end
    endfunction

    // Print one mismatch line (capped) and count it
    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at span %0d: %s got %0d want %0d", spans_checked, what, got, want);
    endtask

    // Monitor: record request handshakes, predict, and check spans in order
    always @(posedge clk)
    begin
        span_due_t want;
        if (rst_n)
        begin
            req_accepted <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (spans_due.size() == 0)
                    report_mismatch("span with none due", int'(m_tdata), 0);
                else
                begin
                    want = spans_due.pop_front();
                    if (m_tdata[5:0] != want.span.row_first)
                        report_mismatch("row_first", m_tdata[5:0], want.span.row_first);
                    if (m_tdata[11:6] != want.span.row_last)
                        report_mismatch("row_last", m_tdata[11:6], want.span.row_last);
                    if (m_tdata[17:12] != want.span.col_first)
                        report_mismatch("col_first", m_tdata[17:12], want.span.col_first);
                    if (m_tdata[23:18] != want.span.col_last)
                        report_mismatch("col_last", m_tdata[23:18], want.span.col_last);
                    if (m_tuser[0] !== want.span.span_empty)
                        report_mismatch("span_empty", m_tuser[0], want.span.span_empty);
                    if (m_tlast !== want.end_of_line)
                        report_mismatch("end_of_line", m_tlast, want.end_of_line);
                end
                spans_checked++;
            end
            if (s_tvalid && s_tready)
                predict_line_spans(s_tdata);
        end
    end

    // Driver: offer the next pending request once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || req_accepted))
        begin
            if (line_reqs_pending.size() != 0 &&
                !(pace == PACE_SLOW_SOURCE ? $urandom_range(0, 99) < 88 :
                  pace == PACE_SLOW_SINK   ? $urandom_range(0, 99) < 13 : 1'b0))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= line_reqs_pending.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Sink: random backpressure in the slow paces, always ready at full pace, plus one long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_go && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (pace == PACE_SLOW_SINK)
            m_tready <= $urandom_range(0, 99) >= 88;
        else if (pace == PACE_SLOW_SOURCE)
            m_tready <= $urandom_range(0, 99) >= 13;
        else
            m_tready <= 1'b1;
    end

    // Block until every request is taken and every span has come back;
    // sample at the rising edge so the driver's pop and offer have settled
    task automatic wait_drained();
        while (line_reqs_pending.size() != 0 || s_tvalid || spans_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one limit register and track it in the predictor
    task automatic write_limit(cfg_reg_t idx, int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 6'(value);
        if (idx == REG_ROW_LIMIT)
            row_lim = value;
        else
            col_lim = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Reconfigure while idle, then queue a batch of random lines
    task automatic run_batch(pace_t p, int rl, int cl, int count, bit hold);
        int r0, c0, r1, c1;
        wait_drained();
        write_limit(REG_ROW_LIMIT, rl);
        write_limit(REG_COL_LIMIT, cl);
        @(posedge clk);
        pace = p;
        hold_go = hold;
        for (int i = 0; i < count; i++)
        begin
            r0 = $urandom_range(0, GRID_MAX);
            c0 = $urandom_range(0, GRID_MAX);
            // Mostly short lines, with a quarter ending anywhere on the grid
            if ($urandom_range(0, 3) == 0)
            begin
                r1 = $urandom_range(0, GRID_MAX);
                c1 = $urandom_range(0, GRID_MAX);
            end
            else
            begin
                r1 = r0 + int'($urandom_range(0, 24)) - 12;
                c1 = c0 + int'($urandom_range(0, 24)) - 12;
                r1 = (r1 < 0) ? 0 : (r1 > GRID_MAX) ? GRID_MAX : r1;
                c1 = (c1 < 0) ? 0 : (c1 > GRID_MAX) ? GRID_MAX : c1;
            end
            line_reqs_pending.push_back(pack_req(r0, c0, r1, c1, $urandom_range(0, 15)));
        end
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines under the reset limits
        line_reqs_pending.push_back(pack_req(5, 5, 5, 5, 3));       // single point
        line_reqs_pending.push_back(pack_req(0, 0, 0, 0, 0));       // single point, no width
        line_reqs_pending.push_back(pack_req(63, 63, 63, 63, 15));  // point outside the limits
        line_reqs_pending.push_back(pack_req(0, 0, 63, 63, 15));    // equal deltas, full length
        line_reqs_pending.push_back(pack_req(63, 0, 0, 63, 1));     // anti-diagonal, reversed
        line_reqs_pending.push_back(pack_req(0, 0, 0, 63, 2));      // horizontal
        line_reqs_pending.push_back(pack_req(0, 63, 0, 0, 7));      // horizontal, reversed
        line_reqs_pending.push_back(pack_req(63, 0, 0, 0, 14));     // vertical, reversed
        line_reqs_pending.push_back(pack_req(3, 2, 12, 7, 4));
        line_reqs_pending.push_back(pack_req(12, 7, 3, 2, 5));
        line_reqs_pending.push_back(pack_req(2, 3, 7, 12, 6));
        line_reqs_pending.push_back(pack_req(7, 12, 2, 3, 8));
        line_reqs_pending.push_back(pack_req(10, 1, 1, 14, 9));
        line_reqs_pending.push_back(pack_req(1, 14, 10, 1, 10));
        line_reqs_pending.push_back(pack_req(20, 20, 30, 25, 3));   // wholly outside the limits
        line_reqs_pending.push_back(pack_req(14, 13, 17, 16, 11));  // crosses the limit corner
        line_reqs_pending.push_back(pack_req(8, 40, 9, 2, 13));
        line_reqs_pending.push_back(pack_req(40, 8, 2, 9, 12));
        line_reqs_pending.push_back(pack_req(5, 5, 6, 6, 0));       // no width, diagonal

        run_batch(PACE_SLOW_SINK, GRID_MAX, GRID_MAX, 60, 1'b0);
        run_batch(PACE_SLOW_SINK, 0, 0, 20, 1'b0);
        run_batch(PACE_SLOW_SOURCE, 40, 22, 50, 1'b0);
        run_batch(PACE_SLOW_SOURCE, GRID_MAX, 0, 20, 1'b0);
        run_batch(PACE_FULL, 0, GRID_MAX, 20, 1'b1);
        run_batch(PACE_FULL, $urandom_range(0, GRID_MAX), $urandom_range(0, GRID_MAX), 50, 1'b0);
        run_batch(PACE_FULL, 31, 47, 60, 1'b0);
        wait_drained();

        if (mismatch_count == 0 && spans_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tlsr_pkg.sv
rtl/core/tlsr_step.sv
rtl/core/tlsr_span.sv
rtl/core/thick_line_span_rasterizer_core.sv
sim/testbench.sv
